/* rtl/data_stack_shuffle_unit_core_defines.svh */
// Assertion macros for the data stack shuffle unit.
// Included by the core; needs nothing else. Bodies are empty under SYNTHESIS.
`ifndef DATA_STACK_SHUFFLE_UNIT_CORE_DEFINES_SVH
`define DATA_STACK_SHUFFLE_UNIT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define DSSU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dssu assertion failed");
// condition in one cycle implies a condition in the next
`define DSSU_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("dssu assertion failed");
`else
`define DSSU_ASSERT(label, clk, rst_n, prop)
`define DSSU_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* rtl/dssu_pkg.sv */
// Package of the data stack shuffle unit: sizes, command and fault codes,
// command and result structs. No dependencies.
package dssu_pkg;

  // stack sizing
  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned TYPE_WIDTH  = 4;
  localparam int unsigned SHUFFLE_MAX = 4;

  // one pick field per pushed copy
  localparam int unsigned PICK_FIELDS = 4;
  localparam int unsigned COPY_N      = (SHUFFLE_MAX < PICK_FIELDS) ? SHUFFLE_MAX : PICK_FIELDS;

  // derived widths
  localparam int unsigned ENTRY_W    = VALUE_WIDTH + TYPE_WIDTH;
  localparam int unsigned ADDR_W     = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W      = $clog2(STACK_DEPTH + 1);
  localparam int unsigned COPY_IDX_W = $clog2(COPY_N);
  localparam int unsigned COPY_CNT_W = $clog2(COPY_N + 1);
  localparam int unsigned PICK_IDX_W = $clog2(PICK_FIELDS);

  // command codes
  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_CHECK = 3'd3,
    CMD_SHUF  = 3'd4
  } cmd_e;

  // fault codes
  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_UNDER = 2'd1,
    FAULT_OVER  = 2'd2,
    FAULT_PICK  = 2'd3
  } fault_e;

  // one stack entry as stored in memory
  typedef struct packed {
    logic [TYPE_WIDTH-1:0]  typ;
    logic [VALUE_WIDTH-1:0] value;
  } entry_t;

  // command transfer
  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] push_value;
    logic [3:0]  push_type;
    logic [7:0]  depth_index;
    logic [3:0]  expected_type;
    logic [2:0]  take_count;
    logic [2:0]  give_count;
    logic [1:0]  pick_first;
    logic [1:0]  pick_second;
    logic [1:0]  pick_third;
    logic [1:0]  pick_fourth;
  } in_t;

  // result transfer
  typedef struct packed {
    logic [31:0] read_value;
    logic [3:0]  read_type;
    logic        type_differs;
    fault_e      fault;
    logic [8:0]  stack_depth_now;
  } out_t;

endpackage

/* rtl/data_stack_shuffle_unit_core.sv */
// Typed data stack with push, pop, peek, type check and shuffle commands.
// Uses dssu_pkg, dssu_ram and data_stack_shuffle_unit_core_defines.svh.
//
//   channel   direction  handshake            payload
//   command   in         start & !busy        req_i  (dssu_pkg::in_t)
//   result    out        done_o, one cycle    res_o  (dssu_pkg::out_t)
//
// Entries live in one single-port RAM; all work goes through its one port.
// busy stays high through decode alone for push, faults, unknown commands and a shuffle that
// gives no copies, through decode and a read-data state for pop, peek and type check, and
// for any other shuffle through decode, the read state (one read per copy), then one write per copy.
// done_o pulses in the first cycle in which busy is low; start is taken in that cycle.
// Reset empties the stack at once; no clearing pass. Results cannot be held off.
`include "data_stack_shuffle_unit_core_defines.svh"

module data_stack_shuffle_unit_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  dssu_pkg::in_t  req_i,
  output logic           busy,
  output logic           done_o,
  output dssu_pkg::out_t res_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_RD   = 5'b00100,
    S_SRD  = 5'b01000,
    S_SWR  = 5'b10000
  } state_e;

  state_e                              state_q, state_d;
  dssu_pkg::in_t                       req_q, req_d;
  logic [dssu_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  logic [dssu_pkg::CNT_W-1:0]          base_q, base_d;
  logic [dssu_pkg::COPY_CNT_W-1:0]     rd_i_q, rd_i_d;
  logic [dssu_pkg::COPY_CNT_W-1:0]     wr_i_q, wr_i_d;
  logic                                cap_v_q, cap_v_d;
  logic [dssu_pkg::COPY_IDX_W-1:0]     cap_idx_q, cap_idx_d;
  dssu_pkg::entry_t                    copy_q [dssu_pkg::COPY_N];
  logic                                done_q, done_d;
  logic [31:0]                         rv_q, rv_d;
  logic [3:0]                          rt_q, rt_d;
  logic                                diff_q, diff_d;
  dssu_pkg::fault_e                    fault_q, fault_d;

  logic                                ram_we, ram_re;
  logic [dssu_pkg::ADDR_W-1:0]         ram_addr;
  dssu_pkg::entry_t                    ram_wdata;
  logic [dssu_pkg::ENTRY_W-1:0]        ram_rdata;
  dssu_pkg::entry_t                    rd_entry;

  logic [1:0]                          picks [dssu_pkg::PICK_FIELDS];
  logic                                shuf_under, shuf_malformed, shuf_pick_bad, shuf_over;
  logic                                peek_under;
  logic [dssu_pkg::CNT_W-1:0]          shuf_base;
  logic [dssu_pkg::ADDR_W-1:0]         peek_addr;
  logic                                rd_issue;
  logic [1:0]                          pick_cur;

  assign busy     = (state_q != S_IDLE);
  assign rd_entry = dssu_pkg::entry_t'(ram_rdata);

  // stack memory
  dssu_ram #(
    .WIDTH(dssu_pkg::ENTRY_W),
    .DEPTH(dssu_pkg::STACK_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // pick fields as an array, deepest taken entry is position 0
  assign picks[0] = req_q.pick_first;
  assign picks[1] = req_q.pick_second;
  assign picks[2] = req_q.pick_third;
  assign picks[3] = req_q.pick_fourth;

  // fault checks and addresses for the latched command
  always_comb begin
    shuf_under     = (dssu_pkg::CNT_W'(req_q.take_count) > cnt_q);
    shuf_malformed = (32'(req_q.take_count) > dssu_pkg::SHUFFLE_MAX) ||
                     (32'(req_q.give_count) > dssu_pkg::SHUFFLE_MAX) ||
                     (32'(req_q.give_count) > dssu_pkg::PICK_FIELDS);
    shuf_pick_bad  = 1'b0;
    for (int k = 0; k < dssu_pkg::PICK_FIELDS; k++) begin
      if ((3'(k) < req_q.give_count) && ({1'b0, picks[k]} >= req_q.take_count)) begin
        shuf_pick_bad = 1'b1;
      end
    end
    shuf_base  = cnt_q - dssu_pkg::CNT_W'(req_q.take_count);
    shuf_over  = ((dssu_pkg::CNT_W + 1)'(shuf_base) + (dssu_pkg::CNT_W + 1)'(req_q.give_count))
                 > (dssu_pkg::CNT_W + 1)'(dssu_pkg::STACK_DEPTH);
    peek_under = (32'(req_q.depth_index) >= 32'(cnt_q));
    peek_addr  = dssu_pkg::ADDR_W'(32'(cnt_q) - 32'd1 - 32'(req_q.depth_index));
    rd_issue   = (3'(rd_i_q) < req_q.give_count);
    pick_cur   = picks[dssu_pkg::PICK_IDX_W'(rd_i_q)];
  end

  // sequencer: decode, memory reads and write-back
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    cnt_d     = cnt_q;
    base_d    = base_q;
    rd_i_d    = rd_i_q;
    wr_i_d    = wr_i_q;
    cap_v_d   = 1'b0;
    cap_idx_d = cap_idx_q;
    done_d    = 1'b0;
    rv_d      = rv_q;
    rt_d      = rt_q;
    diff_d    = diff_q;
    fault_d   = fault_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        rv_d    = '0;
        rt_d    = '0;
        diff_d  = 1'b0;
        fault_d = dssu_pkg::FAULT_NONE;
        case (req_q.cmd)
          dssu_pkg::CMD_PUSH: begin
            done_d  = 1'b1;
            state_d = S_IDLE;
            if (cnt_q >= dssu_pkg::CNT_W'(dssu_pkg::STACK_DEPTH)) begin
              fault_d = dssu_pkg::FAULT_OVER;
            end else begin
              ram_we          = 1'b1;
              ram_addr        = dssu_pkg::ADDR_W'(cnt_q);
              ram_wdata.typ   = dssu_pkg::TYPE_WIDTH'(req_q.push_type);
              ram_wdata.value = dssu_pkg::VALUE_WIDTH'(req_q.push_value);
              cnt_d           = cnt_q + 1'b1;
            end
          end
          dssu_pkg::CMD_POP: begin
            if (cnt_q == '0) begin
              fault_d = dssu_pkg::FAULT_UNDER;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              ram_re   = 1'b1;
              ram_addr = dssu_pkg::ADDR_W'(cnt_q - 1'b1);
              cnt_d    = cnt_q - 1'b1;
              state_d  = S_RD;
            end
          end
          dssu_pkg::CMD_PEEK, dssu_pkg::CMD_CHECK: begin
            if (peek_under) begin
              fault_d = dssu_pkg::FAULT_UNDER;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              ram_re   = 1'b1;
              ram_addr = peek_addr;
              state_d  = S_RD;
            end
          end
          dssu_pkg::CMD_SHUF: begin
            if (shuf_under) begin
              fault_d = dssu_pkg::FAULT_UNDER;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else if (shuf_malformed || shuf_pick_bad) begin
              fault_d = dssu_pkg::FAULT_PICK;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else if (shuf_over) begin
              fault_d = dssu_pkg::FAULT_OVER;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else if (req_q.give_count == '0) begin
              cnt_d   = shuf_base;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              base_d  = shuf_base;
              rd_i_d  = '0;
              state_d = S_SRD;
            end
          end
          default: begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end

      // read data of pop, peek or type check
      S_RD: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (req_q.cmd == dssu_pkg::CMD_CHECK) begin
          diff_d = (rd_entry.typ != dssu_pkg::TYPE_WIDTH'(req_q.expected_type));
        end else begin
          rv_d = 32'(rd_entry.value);
          rt_d = 4'(rd_entry.typ);
        end
      end

      // one picked read per cycle, its data captured in the cycle after the read
      S_SRD: begin
        if (rd_issue) begin
          ram_re    = 1'b1;
          ram_addr  = dssu_pkg::ADDR_W'(base_q + dssu_pkg::CNT_W'(pick_cur));
          rd_i_d    = rd_i_q + 1'b1;
          cap_v_d   = 1'b1;
          cap_idx_d = dssu_pkg::COPY_IDX_W'(rd_i_q);
        end else begin
          wr_i_d  = '0;
          state_d = S_SWR;
        end
      end

      // copies written back from the base of the taken group upward
      S_SWR: begin
        ram_we    = 1'b1;
        ram_addr  = dssu_pkg::ADDR_W'(base_q + dssu_pkg::CNT_W'(wr_i_q));
        ram_wdata = copy_q[dssu_pkg::COPY_IDX_W'(wr_i_q)];
        wr_i_d    = wr_i_q + 1'b1;
        if (3'(wr_i_d) == req_q.give_count) begin
          cnt_d   = base_q + dssu_pkg::CNT_W'(req_q.give_count);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      cap_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      cap_v_q <= cap_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    base_q    <= base_d;
    rd_i_q    <= rd_i_d;
    wr_i_q    <= wr_i_d;
    cap_idx_q <= cap_idx_d;
    rv_q      <= rv_d;
    rt_q      <= rt_d;
    diff_q    <= diff_d;
    fault_q   <= fault_d;
    if (cap_v_q) begin
      copy_q[cap_idx_q] <= rd_entry;
    end
  end

  // result transfer
  assign done_o = done_q;
  always_comb begin
    res_o.read_value      = rv_q;
    res_o.read_type       = rt_q;
    res_o.type_differs    = diff_q;
    res_o.fault           = fault_q;
    res_o.stack_depth_now = 9'(cnt_q);
  end

  // checks
  `DSSU_ASSERT(a_depth_bound, clk_i, rst_ni, cnt_q <= dssu_pkg::CNT_W'(dssu_pkg::STACK_DEPTH))
  `DSSU_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_q, !done_q)
  `DSSU_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `DSSU_ASSERT(a_fault_hold, clk_i, rst_ni, done_q && fault_q != dssu_pkg::FAULT_NONE |-> $stable(cnt_q))

endmodule

/* rtl/dssu_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module dssu_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write, and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sim/testbench.sv */
// Testbench of the data stack shuffle unit: directed and random command transfers,
// each result checked field by field against a shadow copy of the stack.
// Depends on dssu_pkg and data_stack_shuffle_unit_core.
module testbench;

  // command codes the block must ignore
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
  localparam int unsigned GAP_MAX      = 19;
  localparam int unsigned QUIET_TAIL   = 60;
  localparam int unsigned SETTLE_WAIT  = 40;
  localparam int unsigned DRAIN_LIMIT  = 2000;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  logic           done_o;
  dssu_pkg::in_t  req_i;
  dssu_pkg::out_t res_o;

  // shadow stack and results still to come
  dssu_pkg::entry_t shadow_mem [dssu_pkg::STACK_DEPTH];
  int unsigned      shadow_count = 0;
  dssu_pkg::out_t   awaited_results [$];

  int unsigned err_count    = 0;
  int unsigned cmd_count    = 0;
  int unsigned result_count = 0;
  int unsigned deepest      = 0;
  bit          gaps_on      = 1'b1;

  data_stack_shuffle_unit_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // apply one command to the shadow stack and return the result it gives
  function automatic dssu_pkg::out_t apply_stack_cmd(input dssu_pkg::in_t c);
    dssu_pkg::out_t   r;
    dssu_pkg::entry_t e;
    dssu_pkg::entry_t copies [dssu_pkg::PICK_FIELDS];
    logic [1:0]       picks [dssu_pkg::PICK_FIELDS];
    int unsigned      take;
    int unsigned      give;
    int unsigned      base;
    bit               pick_bad;
    r = '0;
    r.fault = dssu_pkg::FAULT_NONE;
    case (c.cmd)
      dssu_pkg::CMD_PUSH: begin
        if (shadow_count >= dssu_pkg::STACK_DEPTH) begin
          r.fault = dssu_pkg::FAULT_OVER;
        end else begin
          e.value = c.push_value;
          e.typ   = c.push_type;
          shadow_mem[shadow_count] = e;
          shadow_count++;
        end
      end
      dssu_pkg::CMD_POP: begin
        if (shadow_count == 0) begin
          r.fault = dssu_pkg::FAULT_UNDER;
        end else begin
          shadow_count--;
          r.read_value = shadow_mem[shadow_count].value;
          r.read_type  = shadow_mem[shadow_count].typ;
        end
      end
      dssu_pkg::CMD_PEEK, dssu_pkg::CMD_CHECK: begin
        if (c.depth_index >= shadow_count) begin
          r.fault = dssu_pkg::FAULT_UNDER;
        end else begin
          e = shadow_mem[shadow_count - 1 - c.depth_index];
          if (c.cmd == dssu_pkg::CMD_PEEK) begin
            r.read_value = e.value;
            r.read_type  = e.typ;
          end else begin
            r.type_differs = (e.typ != c.expected_type);
          end
        end
      end
      dssu_pkg::CMD_SHUF: begin
        take = c.take_count;
        give = c.give_count;
        picks[0] = c.pick_first;
        picks[1] = c.pick_second;
        picks[2] = c.pick_third;
        picks[3] = c.pick_fourth;
        pick_bad = 1'b0;
        // underflow first, then malformed shapes, then depth overflow
        if (take > shadow_count) begin
          r.fault = dssu_pkg::FAULT_UNDER;
        end else if (take > dssu_pkg::SHUFFLE_MAX || give > dssu_pkg::SHUFFLE_MAX ||
                     give > dssu_pkg::PICK_FIELDS) begin
          r.fault = dssu_pkg::FAULT_PICK;
        end else begin
          for (int unsigned i = 0; i < give; i++) begin
            if (picks[i] >= take) pick_bad = 1'b1;
          end
          base = shadow_count - take;
          if (pick_bad) begin
            r.fault = dssu_pkg::FAULT_PICK;
          end else if (base + give > dssu_pkg::STACK_DEPTH) begin
            r.fault = dssu_pkg::FAULT_OVER;
          end else begin
            for (int unsigned i = 0; i < give; i++) copies[i] = shadow_mem[base + picks[i]];
            for (int unsigned i = 0; i < give; i++) shadow_mem[base + i] = copies[i];
            shadow_count = base + give;
          end
        end
      end
      default: begin
      end
    endcase
    r.stack_depth_now = 9'(shadow_count);
    return r;
  endfunction

  // command with every field random, so unused fields toggle too
  function automatic dssu_pkg::in_t scrambled_cmd(input logic [2:0] code);
    dssu_pkg::in_t c;
    c.cmd           = code;
    c.push_value    = $urandom;
    c.push_type     = 4'($urandom);
    c.depth_index   = 8'($urandom);
    c.expected_type = 4'($urandom);
    c.take_count    = 3'($urandom);
    c.give_count    = 3'($urandom);
    c.pick_first    = 2'($urandom);
    c.pick_second   = 2'($urandom);
    c.pick_third    = 2'($urandom);
    c.pick_fourth   = 2'($urandom);
    return c;
  endfunction

  function automatic dssu_pkg::in_t push_cmd(input logic [31:0] value, input logic [3:0] typ);
    dssu_pkg::in_t c;
    c = scrambled_cmd(dssu_pkg::CMD_PUSH);
    c.push_value = value;
    c.push_type  = typ;
    return c;
  endfunction

  function automatic dssu_pkg::in_t index_cmd(input logic [2:0] code, input logic [7:0] depth,
                                              input logic [3:0] etyp);
    dssu_pkg::in_t c;
    c = scrambled_cmd(code);
    c.depth_index   = depth;
    c.expected_type = etyp;
    return c;
  endfunction

  function automatic dssu_pkg::in_t shuffle_cmd(input logic [2:0] take, input logic [2:0] give,
                                                input logic [1:0] p0, input logic [1:0] p1,
                                                input logic [1:0] p2, input logic [1:0] p3);
    dssu_pkg::in_t c;
    c = scrambled_cmd(dssu_pkg::CMD_SHUF);
    c.take_count  = take;
    c.give_count  = give;
    c.pick_first  = p0;
    c.pick_second = p1;
    c.pick_third  = p2;
    c.pick_fourth = p3;
    return c;
  endfunction

  // one command transfer, with an optional idle burst ahead of it
  task automatic issue_cmd(input dssu_pkg::in_t c);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    awaited_results.push_back(apply_stack_cmd(c));
    cmd_count++;
    if (shadow_count > deepest) deepest = shadow_count;
  endtask

  // faults on an empty stack, plus the empty shuffle
  task automatic test_empty_stack();
    issue_cmd(scrambled_cmd(dssu_pkg::CMD_POP));
    issue_cmd(index_cmd(dssu_pkg::CMD_PEEK, 8'd0, 4'd0));
    issue_cmd(index_cmd(dssu_pkg::CMD_CHECK, 8'd0, 4'd0));
    issue_cmd(shuffle_cmd(3'd1, 3'd0, 2'd0, 2'd0, 2'd0, 2'd0));
    issue_cmd(shuffle_cmd(3'd0, 3'd0, 2'd3, 2'd3, 2'd3, 2'd3));
    issue_cmd(shuffle_cmd(3'd0, 3'd1, 2'd0, 2'd0, 2'd0, 2'd0));
  endtask

  // unknown codes leave everything alone
  task automatic test_unknown_cmds();
    for (int unsigned u = CMD_UNUSED_FIRST; u <= CMD_UNUSED_LAST; u++) begin
      issue_cmd(scrambled_cmd(3'(u)));
    end
  endtask

  // field extremes through push, peek, type check and pop
  task automatic test_push_peek_check();
    issue_cmd(push_cmd(32'h0000_0000, 4'h0));
    issue_cmd(push_cmd(32'hFFFF_FFFF, 4'hF));
    issue_cmd(push_cmd(32'h1234_5678, 4'h5));
    issue_cmd(index_cmd(dssu_pkg::CMD_PEEK, 8'd0, 4'd0));
    issue_cmd(index_cmd(dssu_pkg::CMD_PEEK, 8'd2, 4'd0));
    issue_cmd(index_cmd(dssu_pkg::CMD_PEEK, 8'd3, 4'd0));
    issue_cmd(index_cmd(dssu_pkg::CMD_PEEK, 8'd255, 4'd0));
    issue_cmd(index_cmd(dssu_pkg::CMD_CHECK, 8'd0, 4'h5));
    issue_cmd(index_cmd(dssu_pkg::CMD_CHECK, 8'd1, 4'h0));
    issue_cmd(scrambled_cmd(dssu_pkg::CMD_POP));
  endtask

  // shuffle shapes: swap, dup, rotate, bad picks, bad counts, drop
  task automatic test_shuffle_forms();
    issue_cmd(shuffle_cmd(3'd2, 3'd2, 2'd1, 2'd0, 2'd3, 2'd3));
    issue_cmd(shuffle_cmd(3'd1, 3'd2, 2'd0, 2'd0, 2'd2, 2'd1));
    issue_cmd(shuffle_cmd(3'd3, 3'd3, 2'd2, 2'd0, 2'd1, 2'd3));
    issue_cmd(shuffle_cmd(3'd3, 3'd1, 2'd3, 2'd0, 2'd0, 2'd0));
    issue_cmd(shuffle_cmd(3'd2, 3'd5, 2'd0, 2'd1, 2'd0, 2'd1));
    issue_cmd(shuffle_cmd(3'd4, 3'd4, 2'd0, 2'd1, 2'd2, 2'd3));
    issue_cmd(shuffle_cmd(3'd2, 3'd4, 2'd1, 2'd0, 2'd1, 2'd0));
    issue_cmd(shuffle_cmd(3'd1, 3'd0, 2'd2, 2'd2, 2'd2, 2'd2));
  endtask

  // fill to the top, hit overflow and the deepest entry, then unwind
  task automatic test_full_stack();
    while (shadow_count < dssu_pkg::STACK_DEPTH - 1) begin
      issue_cmd(push_cmd($urandom, 4'($urandom)));
    end
    // lands exactly on a full stack
    issue_cmd(shuffle_cmd(3'd1, 3'd2, 2'd0, 2'd0, 2'd1, 2'd1));
    issue_cmd(push_cmd($urandom, 4'($urandom)));
    issue_cmd(shuffle_cmd(3'd1, 3'd2, 2'd0, 2'd0, 2'd0, 2'd0));
    issue_cmd(shuffle_cmd(3'd7, 3'd0, 2'd0, 2'd0, 2'd0, 2'd0));
    issue_cmd(shuffle_cmd(3'd4, 3'd4, 2'd3, 2'd2, 2'd1, 2'd0));
    issue_cmd(index_cmd(dssu_pkg::CMD_PEEK, 8'd255, 4'd0));
    issue_cmd(index_cmd(dssu_pkg::CMD_CHECK, 8'd255, 4'($urandom)));
    while (shadow_count > 8) begin
      if ($urandom_range(0, 1) == 0) begin
        issue_cmd(scrambled_cmd(dssu_pkg::CMD_POP));
      end else begin
        issue_cmd(shuffle_cmd(3'd4, 3'd0, 2'($urandom), 2'($urandom), 2'($urandom),
                              2'($urandom)));
      end
    end
  endtask

  // mostly well-formed commands with random content, some raw noise
  task automatic test_random_mix(input int unsigned n_items);
    dssu_pkg::in_t c;
    int unsigned   sel;
    int unsigned   push_w;
    int unsigned   take;
    for (int unsigned k = 0; k < n_items; k++) begin
      // idle in stretches, none at all near the end
      gaps_on = (k + QUIET_TAIL < n_items) && ((k / 40) % 3 != 2);
      push_w = (shadow_count > 48) ? 18 : 32;
      sel = $urandom_range(0, 99);
      c = scrambled_cmd(dssu_pkg::CMD_PUSH);
      if (sel < push_w) begin
        c.cmd = dssu_pkg::CMD_PUSH;
      end else if (sel < 47) begin
        c.cmd = dssu_pkg::CMD_POP;
      end else if (sel < 73) begin
        c.cmd = (sel < 60) ? dssu_pkg::CMD_PEEK : dssu_pkg::CMD_CHECK;
        if (shadow_count > 0 && $urandom_range(0, 4) != 0) begin
          c.depth_index = 8'($urandom_range(0, shadow_count - 1));
          if (c.cmd == dssu_pkg::CMD_CHECK && $urandom_range(0, 1) == 0) begin
            c.expected_type = shadow_mem[shadow_count - 1 - c.depth_index].typ;
          end
        end
      end else if (sel < 95) begin
        c.cmd = dssu_pkg::CMD_SHUF;
        if ($urandom_range(0, 4) != 0) begin
          take = $urandom_range(0, (shadow_count < 4) ? shadow_count : 4);
          c.take_count = 3'(take);
          c.give_count = 3'($urandom_range(0, 4));
          if (take > 0) begin
            c.pick_first  = 2'($urandom_range(0, take - 1));
            c.pick_second = 2'($urandom_range(0, take - 1));
            c.pick_third  = 2'($urandom_range(0, take - 1));
            c.pick_fourth = 2'($urandom_range(0, take - 1));
          end
        end
      end else begin
        c.cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      end
      issue_cmd(c);
    end
  endtask

  // check each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    dssu_pkg::out_t want;
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with no command waiting for it");
        err_count++;
      end else begin
        want = awaited_results.pop_front();
        result_count++;
        if (res_o.read_value !== want.read_value) begin
          $error("read_value: expected %0h, got %0h", want.read_value, res_o.read_value);
          err_count++;
        end
        if (res_o.read_type !== want.read_type) begin
          $error("read_type: expected %0h, got %0h", want.read_type, res_o.read_type);
          err_count++;
        end
        if (res_o.type_differs !== want.type_differs) begin
          $error("type_differs: expected %0b, got %0b", want.type_differs,
                 res_o.type_differs);
          err_count++;
        end
        if (res_o.fault !== want.fault) begin
          $error("fault: expected %0d, got %0d", want.fault, res_o.fault);
          err_count++;
        end
        if (res_o.stack_depth_now !== want.stack_depth_now) begin
          $error("stack_depth_now: expected %0d, got %0d", want.stack_depth_now,
                 res_o.stack_depth_now);
          err_count++;
        end
      end
    end
  end

  // test sequence
  initial begin
    int unsigned waited;
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_stack();
    test_unknown_cmds();
    test_push_peek_check();
    test_shuffle_forms();
    test_full_stack();
    test_random_mix(170);
    start <= 1'b0;
    // let the last results come out
    waited = 0;
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_WAIT) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      err_count += awaited_results.size();
    end
    $display("Sent %0d commands and checked %0d results; deepest stack was %0d entries",
             cmd_count, result_count, deepest);
    $display("Covered all commands, unknown codes, every fault and a full stack");
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #2000000;
    $error("run timed out");
    $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/dssu_pkg.sv
rtl/dssu_ram.sv
rtl/data_stack_shuffle_unit_core.sv
sim/testbench.sv
